### hw/rtl/assert_macros.svh
// assert_macros.svh: assertion macros shared by the checker files
// depends on nothing; the including module must have clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clk edge, ignored while in reset
`define ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition that must never be true out of reset
`define ASSERT_NEVER(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

### hw/rtl/eprema_pkg.sv
// eprema_pkg: widths, register indexes and constants of the encoder tachometer
// used by encoder_period_rpm_ema_unit and eprema_checker; depends on nothing
`timescale 1ns / 1ps

package eprema_pkg;

    // stream and config port widths
    localparam int IN_DATA_W  = 80;   // event_time[63:0], missed_pulses[79:64]
    localparam int OUT_DATA_W = 48;   // rpm[31:0], last_missed[47:32]
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // field widths
    localparam int TIME_W   = 64;
    localparam int MISS_W   = 16;
    localparam int RPM_W    = 32;
    localparam int PPR_W    = 16;
    localparam int FREQ_W   = 32;
    localparam int ALPHA_W  = 17;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PULSES_PER_REV  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLOCK_FREQUENCY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EMA_ALPHA_Q16   = 2'd2;

    // register reset values
    localparam logic [PPR_W-1:0]   PPR_RESET   = 16'd1;
    localparam logic [FREQ_W-1:0]  FREQ_RESET  = 32'd10000000;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd3277;

    localparam int MISSED_WIDTH_DEF = 16;

    // shift-add multiplier and restoring divider sizes
    localparam int ACC_W  = 80;       // ppr * elapsed_us fits exactly
    localparam int MPL_W  = 20;       // widest multiplier operand (1000000)
    localparam int DIVD_W = 64;       // dividend / quotient shift register
    localparam int DIVR_W = 42;       // divisor and remainder
    localparam int CNT_W  = 7;
    localparam logic [CNT_W-1:0] US_DIV_STEPS  = 7'd64;
    localparam logic [CNT_W-1:0] RPM_DIV_STEPS = 7'd42;

    // arithmetic constants
    localparam logic [MPL_W-1:0]   US_PER_SECOND = 20'd1000000;
    localparam logic [25:0]        US_PER_MINUTE = 26'd60000000;
    localparam logic [ALPHA_W-1:0] Q16_ONE       = 17'h10000;
    localparam logic [RPM_W-1:0]   RPM_MAX       = 32'hFFFF_FFFF;

endpackage

### hw/rtl/encoder_period_rpm_ema_unit.sv
// encoder_period_rpm_ema_unit: period-based tachometer with a Q16 moving average
// depends on eprema_pkg
`timescale 1ns / 1ps

// channel   dir  handshake            payload
// s_        in   s_tvalid/s_tready    s_tdata: event_time, missed_pulses
// m_        out  m_tvalid/m_tready    m_tdata: rpm, last_missed; m_tuser: first_event
// cfg_      in   cfg_we               cfg_index, cfg_wdata
//
// one event at a time; a first event goes straight to ST_OUT and the output register
// later events run through the shift-add multiplies, the 64-step restoring division
// for elapsed microseconds and, bar a zero or 2^42-plus divisor, the 42-step division for the rpm
// multiplies go through one shared shift-add unit, one multiplier bit a cycle
// rst_n clears the state and the config to reset values; no clearing pass
// a new beat is taken while the last result waits; a low m_tready holds the next one in ST_OUT

module encoder_period_rpm_ema_unit #(
    parameter int MISSED_WIDTH = eprema_pkg::MISSED_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // config write port
    input  logic                              cfg_we,
    input  logic [eprema_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [eprema_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [eprema_pkg::IN_DATA_W-1:0]  s_tdata,  // event_time[63:0], missed_pulses[79:64]
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [eprema_pkg::OUT_DATA_W-1:0] m_tdata,  // rpm[31:0], last_missed[47:32]
    output logic                              m_tuser   // first_event[0]
);

    localparam int MW    = (MISSED_WIDTH < eprema_pkg::MISS_W) ? MISSED_WIDTH
                                                               : eprema_pkg::MISS_W;
    localparam int ACC_W = eprema_pkg::ACC_W;
    localparam int MPL_W = eprema_pkg::MPL_W;
    localparam int DVD_W = eprema_pkg::DIVD_W;
    localparam int DVR_W = eprema_pkg::DIVR_W;
    localparam int RPM_W = eprema_pkg::RPM_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_US,
        ST_DIV_US,
        ST_MUL_PE,
        ST_MUL_NUM,
        ST_DIV_RPM,
        ST_EMA_SET,
        ST_MUL_EMA,
        ST_OUT
    } state_t;

    state_t state_reg;

    // config registers
    logic [eprema_pkg::PPR_W-1:0]   ppr_reg;
    logic [eprema_pkg::FREQ_W-1:0]  freq_reg;
    logic [eprema_pkg::ALPHA_W-1:0] alpha_reg;

    // tachometer state
    logic [eprema_pkg::TIME_W-1:0]  prev_time_reg;
    logic                           seen_first_reg;
    logic [RPM_W-1:0]               smoothed_reg;
    logic [MW-1:0]                  stored_missed_reg;

    // current event
    logic [eprema_pkg::TIME_W-1:0]  now_reg;
    logic [MW-1:0]                  missed_reg;
    logic                           first_reg;
    logic [RPM_W-1:0]               raw_reg;
    logic                           d_zero_reg;
    logic                           d_big_reg;

    // shift-add multiplier
    logic [ACC_W-1:0]               acc_reg;
    logic [ACC_W-1:0]               mcand_reg;
    logic [MPL_W-1:0]               mplier_reg;
    logic [ACC_W-1:0]               acc_next;

    // restoring divider
    logic [DVD_W-1:0]               quo_reg;
    logic [DVR_W-1:0]               rem_reg;
    logic [DVR_W-1:0]               div_reg;
    logic [eprema_pkg::CNT_W-1:0]   cnt_reg;
    logic [DVR_W:0]                 div_trial;
    logic                           div_ge;
    logic [DVR_W:0]                 div_diff;
    logic [DVR_W-1:0]               rem_next;

    // output register
    logic                           m_tvalid_reg;
    logic [RPM_W-1:0]               out_rpm_reg;
    logic [eprema_pkg::MISS_W-1:0]  out_missed_reg;
    logic                           out_first_reg;

    // helpers for the setup steps
    logic [eprema_pkg::ALPHA_W-1:0] alpha_eff;
    logic [RPM_W:0]                 ema_diff;
    logic                           s_accept;
    logic                           out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_missed_reg, out_rpm_reg};
    assign m_tuser  = out_first_reg;

    // one multiplier bit per cycle
    assign acc_next = acc_reg + (mplier_reg[0] ? mcand_reg : '0);

    // one quotient bit per cycle
    assign div_trial = {rem_reg, quo_reg[DVD_W-1]};
    assign div_diff  = div_trial - {1'b0, div_reg};
    assign div_ge    = !div_diff[DVR_W];
    assign rem_next  = div_ge ? div_diff[DVR_W-1:0] : div_trial[DVR_W-1:0];

    // clamp alpha to one and form the signed step of the average
    assign alpha_eff = (alpha_reg > eprema_pkg::Q16_ONE) ? eprema_pkg::Q16_ONE : alpha_reg;
    assign ema_diff  = {1'b0, raw_reg} - {1'b0, smoothed_reg};

    // sequencer, datapath and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            ppr_reg           <= eprema_pkg::PPR_RESET;
            freq_reg          <= eprema_pkg::FREQ_RESET;
            alpha_reg         <= eprema_pkg::ALPHA_RESET;
            prev_time_reg     <= '0;
            seen_first_reg    <= 1'b0;
            smoothed_reg      <= '0;
            stored_missed_reg <= '0;
            now_reg           <= '0;
            missed_reg        <= '0;
            first_reg         <= 1'b0;
            raw_reg           <= '0;
            d_zero_reg        <= 1'b0;
            d_big_reg         <= 1'b0;
            acc_reg           <= '0;
            mcand_reg         <= '0;
            mplier_reg        <= '0;
            quo_reg           <= '0;
            rem_reg           <= '0;
            div_reg           <= '0;
            cnt_reg           <= '0;
            m_tvalid_reg      <= 1'b0;
            out_rpm_reg       <= '0;
            out_missed_reg    <= '0;
            out_first_reg     <= 1'b0;
        end
        else
        begin
            // config writes, unknown index ignored
            if (cfg_we)
            begin
                case (cfg_index)
                    eprema_pkg::REG_PULSES_PER_REV:  ppr_reg   <= cfg_wdata[15:0];
                    eprema_pkg::REG_CLOCK_FREQUENCY: freq_reg  <= cfg_wdata;
                    eprema_pkg::REG_EMA_ALPHA_Q16:   alpha_reg <= cfg_wdata[16:0];
                    default: ;
                endcase
            end

            // result taken downstream; in ST_OUT the next result takes its place
            if (m_tvalid_reg && m_tready && (state_reg != ST_OUT))
                m_tvalid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_accept)
                    begin
                        now_reg    <= s_tdata[63:0];
                        missed_reg <= s_tdata[64 +: MW];
                        if (!seen_first_reg)
                        begin
                            // first event only captures the timestamp
                            prev_time_reg  <= s_tdata[63:0];
                            seen_first_reg <= 1'b1;
                            first_reg      <= 1'b1;
                            state_reg      <= ST_OUT;
                        end
                        else
                        begin
                            // ticks times 1000000, kept mod 2^64
                            first_reg  <= 1'b0;
                            acc_reg    <= '0;
                            mcand_reg  <= ACC_W'(s_tdata[63:0] - prev_time_reg);
                            mplier_reg <= eprema_pkg::US_PER_SECOND;
                            state_reg  <= ST_MUL_US;
                        end
                    end
                end

                ST_MUL_US:
                begin
                    if (mplier_reg == '0)
                    begin
                        // elapsed_us = product / frequency, zero frequency as one
                        quo_reg   <= acc_reg[DVD_W-1:0];
                        rem_reg   <= '0;
                        div_reg   <= (freq_reg == '0) ? DVR_W'(1) : DVR_W'(freq_reg);
                        cnt_reg   <= eprema_pkg::US_DIV_STEPS;
                        state_reg <= ST_DIV_US;
                    end
                    else
                    begin
                        acc_reg    <= acc_next;
                        mcand_reg  <= {mcand_reg[ACC_W-2:0], 1'b0};
                        mplier_reg <= {1'b0, mplier_reg[MPL_W-1:1]};
                    end
                end

                ST_DIV_US:
                begin
                    if (cnt_reg == '0)
                    begin
                        // divisor of the rpm: pulses_per_rev * elapsed_us
                        acc_reg    <= '0;
                        mcand_reg  <= ACC_W'(quo_reg);
                        mplier_reg <= MPL_W'(ppr_reg);
                        state_reg  <= ST_MUL_PE;
                    end
                    else
                    begin
                        rem_reg <= rem_next;
                        quo_reg <= {quo_reg[DVD_W-2:0], div_ge};
                        cnt_reg <= cnt_reg - eprema_pkg::CNT_W'(1);
                    end
                end

                ST_MUL_PE:
                begin
                    if (mplier_reg == '0)
                    begin
                        // zero divisor saturates, one of 2^42 or more gives zero
                        d_zero_reg <= (acc_reg == '0);
                        d_big_reg  <= |acc_reg[ACC_W-1:DVR_W];
                        div_reg    <= acc_reg[DVR_W-1:0];
                        // numerator (1 + missed) * 60000000
                        acc_reg    <= '0;
                        mcand_reg  <= ACC_W'(eprema_pkg::US_PER_MINUTE);
                        mplier_reg <= MPL_W'(missed_reg) + MPL_W'(1);
                        state_reg  <= ST_MUL_NUM;
                    end
                    else
                    begin
                        acc_reg    <= acc_next;
                        mcand_reg  <= {mcand_reg[ACC_W-2:0], 1'b0};
                        mplier_reg <= {1'b0, mplier_reg[MPL_W-1:1]};
                    end
                end

                ST_MUL_NUM:
                begin
                    if (mplier_reg == '0)
                    begin
                        if (d_zero_reg)
                        begin
                            raw_reg   <= eprema_pkg::RPM_MAX;
                            state_reg <= ST_EMA_SET;
                        end
                        else if (d_big_reg)
                        begin
                            raw_reg   <= '0;
                            state_reg <= ST_EMA_SET;
                        end
                        else
                        begin
                            // numerator below 2^42, left-aligned in the shifter
                            quo_reg   <= {acc_reg[DVR_W-1:0], (DVD_W - DVR_W)'(0)};
                            rem_reg   <= '0;
                            cnt_reg   <= eprema_pkg::RPM_DIV_STEPS;
                            state_reg <= ST_DIV_RPM;
                        end
                    end
                    else
                    begin
                        acc_reg    <= acc_next;
                        mcand_reg  <= {mcand_reg[ACC_W-2:0], 1'b0};
                        mplier_reg <= {1'b0, mplier_reg[MPL_W-1:1]};
                    end
                end

                ST_DIV_RPM:
                begin
                    if (cnt_reg == '0)
                    begin
                        // saturate quotient to 32 bits
                        raw_reg   <= (|quo_reg[DVR_W-1:RPM_W]) ? eprema_pkg::RPM_MAX
                                                             : quo_reg[RPM_W-1:0];
                        state_reg <= ST_EMA_SET;
                    end
                    else
                    begin
                        rem_reg <= rem_next;
                        quo_reg <= {quo_reg[DVD_W-2:0], div_ge};
                        cnt_reg <= cnt_reg - eprema_pkg::CNT_W'(1);
                    end
                end

                ST_EMA_SET:
                begin
                    // smoothed << 16 plus alpha * (raw - smoothed), two's complement
                    acc_reg    <= {(ACC_W - RPM_W - 16)'(0), smoothed_reg, 16'h0000};
                    mcand_reg  <= {{(ACC_W - RPM_W - 1){ema_diff[RPM_W]}}, ema_diff};
                    mplier_reg <= MPL_W'(alpha_eff);
                    state_reg  <= ST_MUL_EMA;
                end

                ST_MUL_EMA:
                begin
                    if (mplier_reg == '0)
                    begin
                        smoothed_reg      <= acc_reg[RPM_W+15:16];
                        stored_missed_reg <= missed_reg;
                        prev_time_reg     <= now_reg;
                        state_reg         <= ST_OUT;
                    end
                    else
                    begin
                        acc_reg    <= acc_next;
                        mcand_reg  <= {mcand_reg[ACC_W-2:0], 1'b0};
                        mplier_reg <= {1'b0, mplier_reg[MPL_W-1:1]};
                    end
                end

                ST_OUT:
                begin
                    // wait for a free output register
                    if (out_free)
                    begin
                        m_tvalid_reg   <= 1'b1;
                        out_rpm_reg    <= smoothed_reg;
                        out_missed_reg <= eprema_pkg::MISS_W'(stored_missed_reg);
                        out_first_reg  <= first_reg;
                        state_reg      <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### hw/rtl/eprema_checker.sv
// eprema_checker: port-level assertions for encoder_period_rpm_ema_unit, bound in below
// depends on eprema_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module eprema_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [eprema_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                              m_tuser
);

    // one event in flight: input closes right after a beat is taken
    `ASSERT_CLK(a_busy_after_accept, (s_tvalid && s_tready) |=> !s_tready, "input ready after accept")

    // a stalled result beat holds
    `ASSERT_CLK(a_result_holds, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)), "stalled result changed")

    // a new result appears only at the end of a busy period
    `ASSERT_CLK(a_result_from_work, $rose(m_tvalid) |-> $past(!s_tready), "result without work")

    // idle block with its result taken shows no further result
    `ASSERT_CLK(a_no_extra_result, (m_tvalid && m_tready && s_tready) |=> !m_tvalid, "extra result beat")

endmodule

bind encoder_period_rpm_ema_unit eprema_checker u_eprema_checker (.*);

### tb/tb_top.sv
// tb_top: self-checking bench for encoder_period_rpm_ema_unit, a directed table then random phases
// results match typed rows or an in-bench rpm predictor; depends on eprema_pkg and the unit's rtl
`timescale 1ns / 1ps

module tb_top;

    localparam int ITEM_TARGET  = 1850;
    localparam int STALL_LIMIT  = 4000;
    localparam int SETTLE_TICKS = 200;

    // index with no register behind it
    localparam logic [eprema_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [eprema_pkg::RPM_W-1:0]  rpm;
        logic [eprema_pkg::MISS_W-1:0] last_missed;
        logic                          first_event;
    } tach_result_t;

    typedef enum logic {ROW_WRITE, ROW_EVENT} row_kind_t;

    typedef struct packed {
        row_kind_t                         kind;
        logic [eprema_pkg::CFG_IDX_W-1:0]  idx;
        logic [eprema_pkg::CFG_DATA_W-1:0] wdata;
        logic [eprema_pkg::TIME_W-1:0]     stamp;
        logic [eprema_pkg::MISS_W-1:0]     missed;
        logic                              typed;
        tach_result_t                      want;
    } dir_row_t;

    localparam tach_result_t NO_RESULT = '0;
    localparam int DIR_ROWS = 25;

    // directed rows; typed results only where they follow at a glance
    localparam dir_row_t DIR_TBL [DIR_ROWS] = '{
        // first event after reset only captures the timestamp
        '{ROW_EVENT, REG_UNUSED, 32'd0, 64'd100, 16'd0, 1'b1, '{32'd0, 16'd0, 1'b1}},
        '{ROW_WRITE, eprema_pkg::REG_EMA_ALPHA_Q16, 32'h0001_0000, 64'd0, 16'd0, 1'b0,
          NO_RESULT},
        // zero elapsed time saturates
        '{ROW_EVENT, REG_UNUSED, 32'd0, 64'd100, 16'd5, 1'b1,
          '{32'hFFFF_FFFF, 16'd5, 1'b0}},
        '{ROW_WRITE, eprema_pkg::REG_PULSES_PER_REV, 32'd0, 64'd0, 16'd0, 1'b0, NO_RESULT},
        // zero pulses per rev saturates
        '{ROW_EVENT, REG_UNUSED, 32'd0, 64'd1000100, 16'hFFFF, 1'b1,
          '{32'hFFFF_FFFF, 16'hFFFF, 1'b0}},
        '{ROW_WRITE, eprema_pkg::REG_PULSES_PER_REV, 32'd1, 64'd0, 16'd0, 1'b0, NO_RESULT},
        '{ROW_WRITE, eprema_pkg::REG_CLOCK_FREQUENCY, 32'd1000000, 64'd0, 16'd0, 1'b0,
          NO_RESULT},
        // one second per pulse, full weight: 60 rpm
        '{ROW_EVENT, REG_UNUSED, 32'd0, 64'd2000100, 16'd0, 1'b1, '{32'd60, 16'd0, 1'b0}},
        // raw rpm wider than 32 bits saturates
        '{ROW_EVENT, REG_UNUSED, 32'd0, 64'd2000101, 16'hFFFF, 1'b1,
          '{32'hFFFF_FFFF, 16'hFFFF, 1'b0}},
        '{ROW_WRITE, eprema_pkg::REG_EMA_ALPHA_Q16, 32'd0, 64'd0, 16'd0, 1'b0, NO_RESULT},
        // zero weight holds the average
        '{ROW_EVENT, REG_UNUSED, 32'd0, 64'd3000101, 16'd0, 1'b1,
          '{32'hFFFF_FFFF, 16'd0, 1'b0}},
        // weight above one clamps to one
        '{ROW_WRITE, eprema_pkg::REG_EMA_ALPHA_Q16, 32'hFFFF_FFFF, 64'd0, 16'd0, 1'b0,
          NO_RESULT},
        '{ROW_EVENT, REG_UNUSED, 32'd0, 64'd4000101, 16'd1, 1'b1, '{32'd120, 16'd1, 1'b0}},
        // zero clock frequency acts as one tick per second
        '{ROW_WRITE, eprema_pkg::REG_CLOCK_FREQUENCY, 32'd0, 64'd0, 16'd0, 1'b0, NO_RESULT},
        '{ROW_EVENT, REG_UNUSED, 32'd0, 64'd4000102, 16'd0, 1'b1, '{32'd60, 16'd0, 1'b0}},
        // timestamp extremes and wrap of the difference
        '{ROW_EVENT, REG_UNUSED, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF, 16'hAAAA, 1'b0, NO_RESULT},
        '{ROW_EVENT, REG_UNUSED, 32'd0, 64'd0, 16'h5555, 1'b0, NO_RESULT},
        // write to an unused index is dropped
        '{ROW_WRITE, REG_UNUSED, 32'hFFFF_FFFF, 64'd0, 16'd0, 1'b0, NO_RESULT},
        '{ROW_WRITE, eprema_pkg::REG_CLOCK_FREQUENCY, 32'hFFFF_FFFF, 64'd0, 16'd0, 1'b0,
          NO_RESULT},
        '{ROW_WRITE, eprema_pkg::REG_PULSES_PER_REV, 32'hFFFF_FFFF, 64'd0, 16'd0, 1'b0,
          NO_RESULT},
        '{ROW_WRITE, eprema_pkg::REG_EMA_ALPHA_Q16, 32'(eprema_pkg::ALPHA_RESET), 64'd0,
          16'd0, 1'b0, NO_RESULT},
        '{ROW_EVENT, REG_UNUSED, 32'd0, 64'h0123_4567_89AB_CDEF, 16'd0, 1'b0, NO_RESULT},
        '{ROW_EVENT, REG_UNUSED, 32'd0, 64'h8000_0000_0000_0000, 16'h8000, 1'b0, NO_RESULT},
        '{ROW_WRITE, eprema_pkg::REG_CLOCK_FREQUENCY, 32'(eprema_pkg::FREQ_RESET), 64'd0,
          16'd0, 1'b0, NO_RESULT},
        '{ROW_WRITE, eprema_pkg::REG_PULSES_PER_REV, 32'd4, 64'd0, 16'd0, 1'b0, NO_RESULT}
    };

    logic                              clk;
    logic                              rst_n;
    logic                              cfg_we;
    logic [eprema_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [eprema_pkg::CFG_DATA_W-1:0] cfg_wdata;
    logic                              s_tvalid;
    logic                              s_tready;
    logic [eprema_pkg::IN_DATA_W-1:0]  s_tdata;   // event_time[63:0], missed_pulses[79:64]
    logic                              m_tvalid;
    logic                              m_tready;
    logic [eprema_pkg::OUT_DATA_W-1:0] m_tdata;   // rpm[31:0], last_missed[47:32]
    logic                              m_tuser;   // first_event[0]

    // register shadows
    logic [eprema_pkg::PPR_W-1:0]   ppr_reg;
    logic [eprema_pkg::FREQ_W-1:0]  freq_reg;
    logic [eprema_pkg::ALPHA_W-1:0] alpha_reg;

    // predictor state
    logic [eprema_pkg::TIME_W-1:0] pred_prev_time;
    logic                          pred_seen;
    logic [eprema_pkg::RPM_W-1:0]  pred_smoothed;
    logic [eprema_pkg::MISS_W-1:0] pred_missed;

    tach_result_t pending_rpm [$];
    int           fail_count;
    int           events_sent;
    int           quiet_cycles;
    bit           calm;

    encoder_period_rpm_ema_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // smoothed rpm after one event, advancing the predictor state
    function automatic tach_result_t predict_rpm(input logic [eprema_pkg::TIME_W-1:0] stamp,
                                                 input logic [eprema_pkg::MISS_W-1:0] missed);
        logic [63:0]  freq;
        logic [63:0]  elapsed_us;
        logic [63:0]  quot;
        logic [63:0]  raw;
        logic [63:0]  alpha;
        logic [63:0]  mix;
        tach_result_t res;
        res.first_event = 1'b0;
        if (!pred_seen)
        begin
            pred_prev_time  = stamp;
            pred_seen       = 1'b1;
            res.first_event = 1'b1;
        end
        else
        begin
            freq       = (freq_reg == '0) ? 64'd1 : 64'(freq_reg);
            elapsed_us = ((stamp - pred_prev_time) * 64'(eprema_pkg::US_PER_SECOND)) / freq;
            if (elapsed_us == 64'd0 || ppr_reg == '0)
            begin
                raw = 64'(eprema_pkg::RPM_MAX);
            end
            else
            begin
                // floor of floor equals floor of the product divisor
                quot = ((64'd1 + 64'(missed)) * 64'(eprema_pkg::US_PER_MINUTE))
                       / 64'(ppr_reg);
                quot = quot / elapsed_us;
                raw  = (quot > 64'(eprema_pkg::RPM_MAX)) ? 64'(eprema_pkg::RPM_MAX) : quot;
            end
            alpha          = (alpha_reg > eprema_pkg::Q16_ONE) ? 64'(eprema_pkg::Q16_ONE)
                                                               : 64'(alpha_reg);
            mix            = alpha * raw
                             + (64'(eprema_pkg::Q16_ONE) - alpha) * 64'(pred_smoothed);
            pred_smoothed  = mix[47:16];
            pred_missed    = missed;
            pred_prev_time = stamp;
        end
        res.rpm         = pred_smoothed;
        res.last_missed = pred_missed;
        return res;
    endfunction

    // one register write, called at a falling edge while the unit is idle
    task automatic write_reg(input logic [eprema_pkg::CFG_IDX_W-1:0] idx,
                             input logic [eprema_pkg::CFG_DATA_W-1:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        case (idx)
            eprema_pkg::REG_PULSES_PER_REV:  ppr_reg   = data[eprema_pkg::PPR_W-1:0];
            eprema_pkg::REG_CLOCK_FREQUENCY: freq_reg  = data[eprema_pkg::FREQ_W-1:0];
            eprema_pkg::REG_EMA_ALPHA_Q16:   alpha_reg = data[eprema_pkg::ALPHA_W-1:0];
            default:                         ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // one event beat with random idle ahead; the expectation is queued on accept
    task automatic send_event(input logic [eprema_pkg::TIME_W-1:0] stamp,
                              input logic [eprema_pkg::MISS_W-1:0] missed,
                              input logic typed, input tach_result_t want);
        tach_result_t predicted;
        while (!calm && $urandom_range(0, 99) < 33)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {missed, stamp};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = predict_rpm(stamp, missed);
        pending_rpm.push_back(typed ? want : predicted);
        events_sent++;
        @(negedge clk);
    endtask

    // stop sending and wait for every queued result
    task automatic drain_results();
        s_tvalid = 1'b0;
        while (pending_rpm.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // result side back-pressure
    always @(negedge clk)
    begin
        m_tready <= calm || ($urandom_range(0, 99) >= 33);
    end

    // result check against the oldest expectation
    always @(posedge clk)
    begin : check_result
        tach_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_rpm.size() == 0)
            begin
                $error("result beat with nothing expected: rpm %0d",
                       m_tdata[eprema_pkg::RPM_W-1:0]);
                fail_count++;
            end
            else
            begin
                want = pending_rpm.pop_front();
                if (m_tdata[eprema_pkg::RPM_W-1:0] !== want.rpm)
                begin
                    $error("rpm: expected %0d, got %0d", want.rpm,
                           m_tdata[eprema_pkg::RPM_W-1:0]);
                    fail_count++;
                end
                if (m_tdata[eprema_pkg::RPM_W+eprema_pkg::MISS_W-1:eprema_pkg::RPM_W]
                    !== want.last_missed)
                begin
                    $error("last_missed: expected %0d, got %0d", want.last_missed,
                           m_tdata[eprema_pkg::RPM_W+eprema_pkg::MISS_W-1:eprema_pkg::RPM_W]);
                    fail_count++;
                end
                if (m_tuser !== want.first_event)
                begin
                    $error("first_event: expected %0d, got %0d", want.first_event, m_tuser);
                    fail_count++;
                end
            end
        end
    end

    // cycles since the last beat on either stream
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quiet_cycles <= 0;
        end
        else if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // watchdog
    initial
    begin
        wait (rst_n === 1'b1);
        while (quiet_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("tb: failure");
        $finish;
    end

    // stimulus
    initial
    begin
        logic [eprema_pkg::TIME_W-1:0] stamp;
        logic [eprema_pkg::TIME_W-1:0] delta;
        logic [eprema_pkg::MISS_W-1:0] missed;
        int                            span;
        int                            phase;
        int                            sel;

        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_wdata      = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        calm           = 1'b0;
        fail_count     = 0;
        events_sent    = 0;
        ppr_reg        = eprema_pkg::PPR_RESET;
        freq_reg       = eprema_pkg::FREQ_RESET;
        alpha_reg      = eprema_pkg::ALPHA_RESET;
        pred_prev_time = '0;
        pred_seen      = 1'b0;
        pred_smoothed  = '0;
        pred_missed    = '0;
        stamp          = '0;

        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed table
        for (int r = 0; r < DIR_ROWS; r++)
        begin
            if (DIR_TBL[r].kind == ROW_WRITE)
            begin
                drain_results();
                write_reg(DIR_TBL[r].idx, DIR_TBL[r].wdata);
            end
            else
            begin
                stamp = DIR_TBL[r].stamp;
                send_event(stamp, DIR_TBL[r].missed, DIR_TBL[r].typed, DIR_TBL[r].want);
            end
        end

        // random phases, each under its own register setting
        for (phase = 0; events_sent < ITEM_TARGET; phase++)
        begin
            drain_results();
            calm = (phase >= 8 && phase < 12);

            if ($urandom_range(0, 1) == 1)
            begin
                sel = $urandom_range(0, 9);
                case (sel)
                    0:       write_reg(eprema_pkg::REG_PULSES_PER_REV, 32'd0);
                    1, 2:    write_reg(eprema_pkg::REG_PULSES_PER_REV, 32'd1);
                    3:       write_reg(eprema_pkg::REG_PULSES_PER_REV, 32'hFFFF);
                    4:       write_reg(eprema_pkg::REG_PULSES_PER_REV, $urandom);
                    default: write_reg(eprema_pkg::REG_PULSES_PER_REV, $urandom_range(1, 2048));
                endcase
            end
            if ($urandom_range(0, 1) == 1)
            begin
                sel = $urandom_range(0, 9);
                case (sel)
                    0:       write_reg(eprema_pkg::REG_CLOCK_FREQUENCY, 32'd0);
                    1:       write_reg(eprema_pkg::REG_CLOCK_FREQUENCY, 32'd1);
                    2:       write_reg(eprema_pkg::REG_CLOCK_FREQUENCY, 32'd1000000);
                    3:       write_reg(eprema_pkg::REG_CLOCK_FREQUENCY, 32'd100000000);
                    4:       write_reg(eprema_pkg::REG_CLOCK_FREQUENCY, $urandom);
                    5:       write_reg(eprema_pkg::REG_CLOCK_FREQUENCY, 32'hFFFF_FFFF);
                    default: write_reg(eprema_pkg::REG_CLOCK_FREQUENCY,
                                       32'(eprema_pkg::FREQ_RESET));
                endcase
            end
            if ($urandom_range(0, 1) == 1)
            begin
                sel = $urandom_range(0, 9);
                case (sel)
                    0:       write_reg(eprema_pkg::REG_EMA_ALPHA_Q16, 32'd0);
                    1:       write_reg(eprema_pkg::REG_EMA_ALPHA_Q16, 32'(eprema_pkg::Q16_ONE));
                    2:       write_reg(eprema_pkg::REG_EMA_ALPHA_Q16,
                                       $urandom_range(65537, 131071));
                    3:       write_reg(eprema_pkg::REG_EMA_ALPHA_Q16, $urandom);
                    4:       write_reg(eprema_pkg::REG_EMA_ALPHA_Q16,
                                       32'(eprema_pkg::ALPHA_RESET));
                    default: write_reg(eprema_pkg::REG_EMA_ALPHA_Q16, $urandom_range(1, 65535));
                endcase
            end
            if ($urandom_range(0, 7) == 0)
                write_reg(REG_UNUSED, $urandom);

            repeat ($urandom_range(20, 80))
            begin
                // mostly forward steps of realistic size, some arbitrary timestamps
                if ($urandom_range(0, 99) < 85)
                begin
                    span  = ($urandom_range(0, 99) < 70) ? $urandom_range(10, 28)
                                                         : $urandom_range(0, 64);
                    delta = {$urandom, $urandom} >> (64 - span);
                    stamp = stamp + delta;
                end
                else
                begin
                    stamp = {$urandom, $urandom};
                end
                sel = $urandom_range(0, 99);
                if (sel < 60)
                    missed = eprema_pkg::MISS_W'($urandom_range(0, 3));
                else if (sel < 85)
                    missed = eprema_pkg::MISS_W'($urandom_range(0, 65535));
                else if (sel < 93)
                    missed = 16'hFFFF;
                else
                    missed = 16'd0;
                send_event(stamp, missed, 1'b0, NO_RESULT);
            end
        end

        drain_results();
        calm = 1'b0;
        repeat (SETTLE_TICKS) @(posedge clk);

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
